/* src/cdc_pkg.sv */
// Shared constants, command and message codes, and the job record for the
// coherence directory controller. No dependencies.
`timescale 1ns / 1ps

package cdc_pkg;

    // Field widths of the stream beats.
    localparam int CMD_W    = 3;
    localparam int ENTRY_W  = 10;
    localparam int CLIENT_W = 4;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Every client number that a four-bit field can name.
    localparam int TARGETS = 1 << CLIENT_W;

    // Packed payload widths, padded to whole bytes.
    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    localparam int DEF_ENTRIES = 1024;
    localparam int DEF_CLIENTS = 16;

    localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ATTR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

    localparam logic [KIND_W-1:0] KIND_INV    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REVOKE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SELF    = 2'd2;

    // Work handed from the directory update to the message generator.
    typedef struct packed {
        logic [TARGETS-1:0]  mask;
        logic [KIND_W-1:0]   kind;
        logic [ENTRY_W-1:0]  entry;
        logic [STATUS_W-1:0] status;
    } cdc_job_t;

endpackage

/* src/cdc_dir_mem.sv */
// Directory entry memory: one write port, one registered read port, and the
// clearing sweep that sets up the reset contents. Depends on nothing else.
`timescale 1ns / 1ps

module cdc_dir_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int WORD_W = 22
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata,
    output logic              clearing
);

    logic [WORD_W-1:0] mem [DEPTH];

    logic              clearing_reg;
    logic              clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    logic [WORD_W-1:0] rdata_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // The root entry comes out of the sweep valid; all else is zero.
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = {(clr_addr_reg == ADDR_W'(1)), {(WORD_W - 1){1'b0}}};
        end
        else
        begin
            mem_we    = we;
            mem_addr  = waddr;
            mem_wdata = wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

/* src/cdc_msg_gen.sv */
// Message generator: walks a target mask in ascending client order, sends one
// beat per target, then the done beat, through the output register.
// Depends on cdc_pkg.
`timescale 1ns / 1ps

module cdc_msg_gen (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  cdc_pkg::cdc_job_t       job,
    output logic                    busy,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // m_tdata, lowest bit up: kind[1:0], target[5:2], entry_out[15:6],
    // status[17:16], zero fill.
    output logic [cdc_pkg::OUT_W-1:0] m_tdata,
    output logic                    m_tlast
);

    import cdc_pkg::*;

    logic             busy_reg;
    cdc_job_t         job_reg;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;

    logic                slot_free;
    logic [TARGETS-1:0]  low_bit;
    logic [CLIENT_W-1:0] low_idx;

    assign slot_free = !m_tvalid_reg || m_tready;

    // Isolate the lowest pending target and encode its number.
    always_comb
    begin
        low_bit = job_reg.mask & (~job_reg.mask + TARGETS'(1));
        low_idx = '0;
        for (int i = 0; i < TARGETS; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | CLIENT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && slot_free && job_reg.mask == '0)
            begin
                busy_reg <= 1'b0;
            end

            if (busy_reg && slot_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= job;
        end
        else if (busy_reg && slot_free)
        begin
            if (job_reg.mask != '0)
            begin
                m_tdata_reg  <= OUT_W'({ST_OK, job_reg.entry, low_idx, job_reg.kind});
                m_tlast_reg  <= 1'b0;
                job_reg.mask <= job_reg.mask & ~low_bit;
            end
            else
            begin
                m_tdata_reg <= OUT_W'({job_reg.status, job_reg.entry,
                                       {CLIENT_W{1'b0}}, KIND_DONE});
                m_tlast_reg <= 1'b1;
            end
        end
    end

    assign busy     = busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* src/coherence_directory_controller.sv */
// Top level of the coherence directory controller: command intake, the
// read-modify-write of one directory entry, and the message generator.
// Depends on cdc_pkg, cdc_dir_mem and cdc_msg_gen.
`timescale 1ns / 1ps

// Each command beat looks up one directory entry, updates it where needed and
// answers with zero or more invalidate or revoke beats in ascending client
// order, followed by one done beat (tlast high) that carries the status. A
// command has 0 to 15 messages. It is accepted and its memory read issued,
// then its entry is updated and written back, then one output beat per
// message plus the done beat go out, all through the single output register.
// A new command is taken while the previous done beat still waits at the
// output. After reset the entry memory is swept over its min(ENTRIES, 1024)
// entries, during which s_tready stays low. Entries at or above ENTRIES are
// reported missing by the known commands.
module coherence_directory_controller #(
    parameter int ENTRIES = cdc_pkg::DEF_ENTRIES,
    parameter int CLIENTS = cdc_pkg::DEF_CLIENTS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // s_tdata, lowest bit up: cmd[2:0], entry[12:3], client[16:13],
    // payload_empty[17], zero fill.
    input  logic [cdc_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // m_tdata, lowest bit up: kind[1:0], target[5:2], entry_out[15:6],
    // status[17:16], zero fill.
    output logic [cdc_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast
);

    import cdc_pkg::*;

    localparam int MEM_DEPTH = (ENTRIES < (1 << ENTRY_W)) ? ENTRIES : (1 << ENTRY_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SHARER_W  = (CLIENTS < TARGETS) ? CLIENTS : TARGETS;
    localparam int WORD_W    = 2 + CLIENT_W + SHARER_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic state_reg;
    logic state_next;

    logic [CMD_W-1:0]    cmd_reg;
    logic [ENTRY_W-1:0]  entry_reg;
    logic [CLIENT_W-1:0] client_reg;
    logic                empty_reg;

    logic [ENTRY_W-1:0] in_entry;
    logic               accept;
    logic               clearing;
    logic               gen_busy;

    logic [WORD_W-1:0]   rdata;
    logic                rd_valid;
    logic                rd_excl;
    logic [CLIENT_W-1:0] rd_writer;
    logic [SHARER_W-1:0] rd_sharers;

    logic                upd_we;
    logic                nv;
    logic                ne;
    logic [CLIENT_W-1:0] nw;
    logic [SHARER_W-1:0] ns;
    logic [WORD_W-1:0]   wdata;
    logic [TARGETS-1:0]  sharers_t;
    logic [TARGETS-1:0]  client_bit;
    logic [TARGETS-1:0]  writer_bit;
    logic                in_range;
    cdc_job_t            job;

    assign in_entry = s_tdata[CMD_W +: ENTRY_W];
    assign s_tready = (state_reg == ST_IDLE) && !clearing && !gen_busy;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tdata[CMD_W-1:0];
            entry_reg  <= in_entry;
            client_reg <= s_tdata[CMD_W + ENTRY_W +: CLIENT_W];
            empty_reg  <= s_tdata[CMD_W + ENTRY_W + CLIENT_W];
        end
    end

    cdc_dir_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W),
        .WORD_W (WORD_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (upd_we && (state_reg == ST_EVAL)),
        .waddr    (entry_reg[ADDR_W-1:0]),
        .wdata    (wdata),
        .raddr    (in_entry[ADDR_W-1:0]),
        .rdata    (rdata),
        .clearing (clearing)
    );

    assign rd_valid   = rdata[WORD_W-1];
    assign rd_excl    = rdata[WORD_W-2];
    assign rd_writer  = rdata[SHARER_W +: CLIENT_W];
    assign rd_sharers = rdata[SHARER_W-1:0];

    assign sharers_t  = TARGETS'(rd_sharers);
    assign client_bit = TARGETS'(1) << client_reg;
    assign writer_bit = TARGETS'(1) << rd_writer;
    assign in_range   = 32'(entry_reg) < ENTRIES;
    assign wdata      = {nv, ne, nw, ns};

    // Decide the messages and the new entry contents from the read data.
    always_comb
    begin
        job.mask   = '0;
        job.kind   = KIND_INV;
        job.entry  = entry_reg;
        job.status = ST_OK;
        upd_we     = 1'b0;
        nv         = rd_valid;
        ne         = rd_excl;
        nw         = rd_writer;
        ns         = rd_sharers;
        priority if (cmd_reg > CMD_REMOVE)
        begin
            job.status = ST_OK;
        end
        else if (cmd_reg == CMD_WRITE && entry_reg == ENTRY_W'(1) && empty_reg)
        begin
            // Root initialization write: nothing to do.
            job.status = ST_OK;
        end
        else if (!in_range || (cmd_reg != CMD_CREATE && !rd_valid))
        begin
            job.status = ST_MISSING;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_CREATE:
                begin
                    upd_we = 1'b1;
                    nv     = 1'b1;
                    ne     = 1'b1;
                    nw     = client_reg;
                    ns     = '0;
                end
                CMD_WRITE:
                begin
                    if (!rd_excl)
                    begin
                        job.mask = sharers_t & ~client_bit;
                        upd_we   = 1'b1;
                        ne       = 1'b1;
                        nw       = client_reg;
                        ns       = '0;
                    end
                    else if (rd_writer == client_reg)
                    begin
                        job.status = ST_SELF;
                    end
                    else
                    begin
                        job.mask = writer_bit;
                        upd_we   = 1'b1;
                        nw       = client_reg;
                    end
                end
                CMD_READ:
                begin
                    if (rd_excl)
                    begin
                        job.mask = writer_bit;
                        job.kind = KIND_REVOKE;
                    end
                    upd_we = 1'b1;
                    ne     = 1'b0;
                    // Clients beyond the sharer mask shift out and are not recorded.
                    ns     = rd_sharers | (SHARER_W'(1) << client_reg);
                end
                CMD_ATTR:
                begin
                    if (rd_excl && rd_writer != client_reg)
                    begin
                        job.mask = writer_bit;
                        job.kind = KIND_REVOKE;
                        upd_we   = 1'b1;
                        ne       = 1'b0;
                    end
                end
                CMD_REMOVE:
                begin
                    if (rd_excl)
                    begin
                        job.mask = writer_bit & ~client_bit;
                    end
                    else
                    begin
                        job.mask = sharers_t & ~client_bit;
                    end
                    upd_we = 1'b1;
                    nv     = 1'b0;
                    ne     = 1'b0;
                    nw     = '0;
                    ns     = '0;
                end
                default:
                begin
                    job.status = ST_OK;
                end
            endcase
        end
    end

    cdc_msg_gen u_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_EVAL),
        .job      (job),
        .busy     (gen_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/cdc_checker.sv */
// Port-level checks for the coherence directory controller, bound to the top
// level. Depends on cdc_pkg and coherence_directory_controller.
`timescale 1ns / 1ps

module cdc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic [cdc_pkg::IN_W-1:0]  s_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [cdc_pkg::OUT_W-1:0] m_tdata,
    input logic                      m_tlast
);

    import cdc_pkg::*;

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn while stalled");

    // Only the done beat closes a command.
    a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[1:0] == KIND_DONE) == m_tlast))
        else $error("tlast does not match the done beat");

    // Messages carry an ok status.
    a_msg_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[17:16] == ST_OK))
        else $error("message beat with a nonzero status");

    // The done beat addresses no client.
    a_done_target: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[5:2] == '0))
        else $error("done beat with a nonzero target");

    // One command at a time: intake closes right after a command beat.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while one is in progress");

endmodule

bind coherence_directory_controller cdc_checker u_cdc_checker (.*);
